FILE: hdl/crb_pkg.sv
// ----------------------------------------------------------------------------
// crb_pkg
// Shared types, constants and helpers of the cubic bisection root finder.
// ----------------------------------------------------------------------------
`default_nettype none

package crb_pkg;

  localparam int WORD_W    = 32;   // Q16.16 data word
  localparam int FRAC_BITS = 16;
  localparam int TOL_W     = 31;
  localparam int ITER_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W    = 2;    // Horner step counter
  localparam int LAST_STEP = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CUBE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SQUARE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINEAR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd5;

  // reset values
  localparam logic [WORD_W-1:0] RST_CUBE   = 32'sd65536;
  localparam logic [WORD_W-1:0] RST_SQUARE = 32'sd0;
  localparam logic [WORD_W-1:0] RST_LINEAR = -32'sd589824;
  localparam logic [WORD_W-1:0] RST_CONST  = 32'sd196608;
  localparam logic [TOL_W-1:0]  RST_TOL    = 31'd66;
  localparam logic [ITER_W-1:0] RST_LIMIT  = 16'd1000;

  // which point of the bracket the shared evaluator works on
  typedef enum logic [1:0] {
    PT_LOW,
    PT_HIGH,
    PT_MID
  } point_e;

  typedef struct packed {
    logic pos;
    logic neg;
  } sign_t;

  typedef struct packed {
    logic                 load;     // capture a new bracket
    logic                 mid;      // compute the midpoint
    logic                 mul;      // multiply stage of one Horner step
    logic                 acc;      // add/saturate stage of one Horner step
    logic                 decide;   // pick the half, count the iteration
    logic                 finish;   // load the result register
    point_e               pt;
    logic [STEP_W-1:0]    step;
    logic                 hit;
    logic                 narrow;
  } dp_cmd_t;

  typedef struct packed {
    logic below_tol;
    logic limit_reached;
  } dp_status_t;

  // saturate a one-bit-grown sum back to the word
  function automatic logic [WORD_W-1:0] sat_word(input logic [WORD_W:0] v);
    logic [WORD_W-1:0] r;
    if (v[WORD_W] != v[WORD_W-1]) begin
      r = v[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/cubic_root_bisection.sv
// ----------------------------------------------------------------------------
// cubic_root_bisection
// Bisection root finder for a programmable Q16.16 cubic over one bracket.
//
//   channel   direction  handshake               payload
//   input     in         in_valid_i / in_stall_o   lower_i, upper_i
//   result    out        out_valid_o / out_stall_i root_o, limit_hit_o,
//                                                 narrow_start_o, iterations_o
//   config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Each evaluation of the cubic is three Horner steps, each a multiply and an
// add/saturate on the shared 32x32 multiplier; a too narrow start bracket
// skips evaluation, else the two ends are evaluated once and the midpoint once
// per iteration. One item is in work at a time; the next can be taken while
// the last result still waits. Reset is asynchronous, active low, and loads
// the default cubic x^3 - 9x + 3, tolerance 66 and limit 1000.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_root_bisection (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [crb_pkg::WORD_W-1:0] lower_i,
  input  wire logic signed [crb_pkg::WORD_W-1:0] upper_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [crb_pkg::WORD_W-1:0]      root_o,
  output logic                                   limit_hit_o,
  output logic                                   narrow_start_o,
  output logic [crb_pkg::ITER_W-1:0]             iterations_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [crb_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [31:0]                       cfg_data_i
);

  crb_pkg::dp_cmd_t    cmd;
  crb_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  crb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  crb_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .lower_i        (lower_i),
    .upper_i        (upper_i),
    .root_o         (root_o),
    .limit_hit_o    (limit_hit_o),
    .narrow_start_o (narrow_start_o),
    .iterations_o   (iterations_o)
  );

endmodule

`default_nettype wire

FILE: hdl/crb_datapath.sv
// ----------------------------------------------------------------------------
// crb_datapath
// Bracket registers, coefficient registers, shared multiplier for Horner
// evaluation of the cubic, sign bookkeeping and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module crb_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire crb_pkg::dp_cmd_t                cmd_i,
  output crb_pkg::dp_status_t                  status_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [crb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [31:0]                     cfg_data_i,
  input  wire logic signed [crb_pkg::WORD_W-1:0] lower_i,
  input  wire logic signed [crb_pkg::WORD_W-1:0] upper_i,
  output logic signed [crb_pkg::WORD_W-1:0]    root_o,
  output logic                                 limit_hit_o,
  output logic                                 narrow_start_o,
  output logic [crb_pkg::ITER_W-1:0]           iterations_o
);

  localparam int W  = crb_pkg::WORD_W;
  localparam int PW = 2 * crb_pkg::WORD_W;
  localparam logic signed [PW-1:0] P_MAX = {{(W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [PW-1:0] P_MIN = ~P_MAX;
  localparam logic [PW-1:0] FRAC_MASK = {{(PW-crb_pkg::FRAC_BITS){1'b0}},
                                         {crb_pkg::FRAC_BITS{1'b1}}};

  logic signed [W-1:0] cube_q, square_q, linear_q, const_q;
  logic [crb_pkg::TOL_W-1:0]  tol_q;
  logic [crb_pkg::ITER_W-1:0] limit_q;

  logic signed [W-1:0] low_q, high_q, mid_q, t_q;
  logic signed [PW-1:0] prod_q;
  logic [crb_pkg::ITER_W-1:0] iter_q;
  crb_pkg::sign_t sgn_low_q, sgn_high_q, sgn_mid_q;

  logic signed [W-1:0]  x_sel, a_sel, c_sel, prod_sat, t_d;
  logic signed [PW-1:0] prod_adj, prod_shr;
  logic signed [W:0]    width, pair_sum, acc_sum;
  crb_pkg::sign_t       sgn_new;
  logic                 opp_low, opp_high;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cube_q   <= crb_pkg::RST_CUBE;
      square_q <= crb_pkg::RST_SQUARE;
      linear_q <= crb_pkg::RST_LINEAR;
      const_q  <= crb_pkg::RST_CONST;
      tol_q    <= crb_pkg::RST_TOL;
      limit_q  <= crb_pkg::RST_LIMIT;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        crb_pkg::REG_CUBE:   cube_q   <= cfg_data_i;
        crb_pkg::REG_SQUARE: square_q <= cfg_data_i;
        crb_pkg::REG_LINEAR: linear_q <= cfg_data_i;
        crb_pkg::REG_CONST:  const_q  <= cfg_data_i;
        crb_pkg::REG_TOL:    tol_q    <= cfg_data_i[crb_pkg::TOL_W-1:0];
        crb_pkg::REG_LIMIT:  limit_q  <= cfg_data_i[crb_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd_i.pt)
      crb_pkg::PT_LOW:  x_sel = low_q;
      crb_pkg::PT_HIGH: x_sel = high_q;
      default:          x_sel = mid_q;
    endcase
    case (cmd_i.step)
      2'd0:    c_sel = square_q;
      2'd1:    c_sel = linear_q;
      default: c_sel = const_q;
    endcase
  end

  assign a_sel = (cmd_i.step == '0) ? cube_q : t_q;

  // product >> FRAC_BITS toward zero, then saturate to the word
  assign prod_adj = prod_q + (prod_q[PW-1] ? $signed(FRAC_MASK) : '0);
  assign prod_shr = prod_adj >>> crb_pkg::FRAC_BITS;

  always_comb begin
    if (prod_shr > P_MAX) begin
      prod_sat = P_MAX[W-1:0];
    end else if (prod_shr < P_MIN) begin
      prod_sat = P_MIN[W-1:0];
    end else begin
      prod_sat = prod_shr[W-1:0];
    end
  end

  assign acc_sum = {prod_sat[W-1], prod_sat} + {c_sel[W-1], c_sel};
  assign t_d     = crb_pkg::sat_word(acc_sum);
  assign sgn_new.neg = t_d[W-1];
  assign sgn_new.pos = !t_d[W-1] && (|t_d);

  assign width    = {high_q[W-1], high_q} - {low_q[W-1], low_q};
  assign pair_sum = {high_q[W-1], high_q} + {low_q[W-1], low_q};

  assign opp_low  = (sgn_mid_q.pos && sgn_low_q.neg) || (sgn_mid_q.neg && sgn_low_q.pos);
  assign opp_high = (sgn_mid_q.pos && sgn_high_q.neg) || (sgn_mid_q.neg && sgn_high_q.pos);

  assign status_o.below_tol =
    width < $signed({{(W+1-crb_pkg::TOL_W){1'b0}}, tol_q});
  assign status_o.limit_reached = (iter_q >= limit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q      <= '0;
      high_q     <= '0;
      mid_q      <= '0;
      iter_q     <= '0;
      sgn_low_q  <= '0;
      sgn_high_q <= '0;
      sgn_mid_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        low_q  <= lower_i;
        high_q <= upper_i;
        iter_q <= '0;
      end
      if (cmd_i.mid) begin
        mid_q <= pair_sum[W:1];   // floor of the half sum
      end
      if (cmd_i.acc && (cmd_i.step == crb_pkg::STEP_W'(crb_pkg::LAST_STEP))) begin
        case (cmd_i.pt)
          crb_pkg::PT_LOW:  sgn_low_q  <= sgn_new;
          crb_pkg::PT_HIGH: sgn_high_q <= sgn_new;
          default:          sgn_mid_q  <= sgn_new;
        endcase
      end
      if (cmd_i.decide) begin
        // signs of the ends follow the bracket, so each end is evaluated once
        if (opp_low) begin
          high_q     <= mid_q;
          sgn_high_q <= sgn_mid_q;
        end else if (opp_high) begin
          low_q     <= mid_q;
          sgn_low_q <= sgn_mid_q;
        end
        iter_q <= iter_q + 1'b1;
      end
    end
  end

  // datapath-only registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= a_sel * x_sel;
    end
    if (cmd_i.acc) begin
      t_q <= t_d;
    end
    if (cmd_i.finish) begin
      root_o         <= cmd_i.narrow ? crb_pkg::sat_word(width) : mid_q;
      limit_hit_o    <= cmd_i.hit;
      narrow_start_o <= cmd_i.narrow;
      iterations_o   <= iter_q;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/crb_ctrl.sv
// ----------------------------------------------------------------------------
// crb_ctrl
// Sequencer: bracket load, end-point evaluation, bisection loop, result
// handoff through the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module crb_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  input  wire crb_pkg::dp_status_t status_i,
  output crb_pkg::dp_cmd_t         cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_ACC    = 3'd3;
  localparam logic [2:0] S_MID    = 3'd4;
  localparam logic [2:0] S_DECIDE = 3'd5;
  localparam logic [2:0] S_TEST   = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_q, state_d;
  crb_pkg::point_e pt_q, pt_d;
  logic [crb_pkg::STEP_W-1:0] step_q, step_d;
  logic hit_q, hit_d, narrow_q, narrow_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    pt_d        = pt_q;
    step_d      = step_q;
    hit_d       = hit_q;
    narrow_d    = narrow_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.pt    = pt_q;
    cmd_o.step  = step_q;
    cmd_o.hit   = hit_q;
    cmd_o.narrow = narrow_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        hit_d = 1'b0;
        if (status_i.below_tol) begin
          narrow_d = 1'b1;
          state_d  = S_DONE;
        end else begin
          narrow_d = 1'b0;
          pt_d     = crb_pkg::PT_LOW;
          step_d   = '0;
          state_d  = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        if (step_q == crb_pkg::STEP_W'(crb_pkg::LAST_STEP)) begin
          step_d = '0;
          case (pt_q)
            crb_pkg::PT_LOW: begin
              pt_d    = crb_pkg::PT_HIGH;
              state_d = S_MUL;
            end
            crb_pkg::PT_HIGH: state_d = S_MID;
            default:          state_d = S_DECIDE;
          endcase
        end else begin
          step_d  = step_q + 1'b1;
          state_d = S_MUL;
        end
      end
      S_MID: begin
        cmd_o.mid = 1'b1;
        pt_d      = crb_pkg::PT_MID;
        step_d    = '0;
        state_d   = S_MUL;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = S_TEST;
      end
      S_TEST: begin
        if (status_i.limit_reached) begin
          hit_d   = 1'b1;
          state_d = S_DONE;
        end else if (status_i.below_tol) begin
          state_d = S_DONE;
        end else begin
          state_d = S_MID;
        end
      end
      S_DONE: begin
        // wait until the previous result has left the output register
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pt_q        <= crb_pkg::PT_LOW;
      step_q      <= '0;
      hit_q       <= 1'b0;
      narrow_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pt_q        <= pt_d;
      step_q      <= step_d;
      hit_q       <= hit_d;
      narrow_q    <= narrow_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/crb_checker.sv
// ----------------------------------------------------------------------------
// crb_checker
// Port-level checks of the bisection root finder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module crb_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic                          limit_hit_o,
  input wire logic                          narrow_start_o,
  input wire logic [crb_pkg::ITER_W-1:0]    iterations_o
);

  // an accepted item keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after an item");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(limit_hit_o && narrow_start_o))
    else $error("limit and narrow flags both set");

  a_narrow_no_iter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && narrow_start_o |-> iterations_o == '0)
    else $error("narrow start reports iterations");

  a_search_iterates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !narrow_start_o |-> iterations_o != '0)
    else $error("search result without an iteration");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result dropped");

endmodule

bind cubic_root_bisection crb_checker u_crb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .limit_hit_o    (limit_hit_o),
  .narrow_start_o (narrow_start_o),
  .iterations_o   (iterations_o)
);

`default_nettype wire

FILE: tb/tb_cubic_root_bisection.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cubic_root_bisection
// Self-checking bench for the cubic bisection root finder. A directed table
// of brackets and register writes runs first. Random brackets follow under
// four handshake pressure settings. Every result is compared field by field
// with a typed expectation or an in-bench bisection predictor.
// ----------------------------------------------------------------------------

module tb_cubic_root_bisection;

  localparam int          HALF_PERIOD = 6;
  localparam int          RESET_CYCLES = 7;
  localparam int          ITEMS_PER_PHASE = 30;
  // sized to outlast the worst search, at the top iteration limit
  localparam int unsigned WATCHDOG_CYCLES = 2_400_000;
  localparam longint      W_MAX = 64'sd2147483647;
  localparam longint      W_MIN = -64'sd2147483648;
  localparam longint      ONE_Q = 64'sd65536;
  // not mapped, write is dropped
  localparam logic [crb_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic signed [crb_pkg::WORD_W-1:0] root;
    logic                              limit_hit;
    logic                              narrow_start;
    logic [crb_pkg::ITER_W-1:0]        iterations;
  } search_res_t;

  typedef struct {
    bit                                is_cfg;
    logic [crb_pkg::CFG_IDX_W-1:0]     idx;
    logic [31:0]                       data;
    logic signed [crb_pkg::WORD_W-1:0] lo;
    logic signed [crb_pkg::WORD_W-1:0] hi;
    bit                                typed;
    search_res_t                       res;
  } dir_row_t;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               in_valid_i;
  logic                               in_stall_o;
  logic signed [crb_pkg::WORD_W-1:0]  lower_i;
  logic signed [crb_pkg::WORD_W-1:0]  upper_i;
  logic                               out_valid_o;
  logic                               out_stall_i;
  logic signed [crb_pkg::WORD_W-1:0]  root_o;
  logic                               limit_hit_o;
  logic                               narrow_start_o;
  logic [crb_pkg::ITER_W-1:0]         iterations_o;
  logic                               cfg_valid_i;
  logic                               cfg_ready_o;
  logic [crb_pkg::CFG_IDX_W-1:0]      cfg_index_i;
  logic [31:0]                        cfg_data_i;

  // predictor copy of the register file
  longint      cf_cube, cf_square, cf_linear, cf_const;
  longint      tol_q;
  int unsigned lim_q;

  search_res_t pending_searches[$];
  search_res_t want;
  dir_row_t    dir_rows[$];

  int unsigned send_idle_pct, stall_pct;
  int unsigned idle_cycles;
  int          fail_cnt, items_sent, results_seen, narrow_seen, hit_seen, cfg_writes;

  cubic_root_bisection u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .lower_i        (lower_i),
    .upper_i        (upper_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .root_o         (root_o),
    .limit_hit_o    (limit_hit_o),
    .narrow_start_o (narrow_start_o),
    .iterations_o   (iterations_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic longint clamp_w(input longint v);
    longint r;
    r = v;
    if (v > W_MAX) r = W_MAX;
    if (v < W_MIN) r = W_MIN;
    return r;
  endfunction

  // (a*b) >> 16 truncated toward zero, saturated to the word
  function automatic longint fix_mul(input longint a, input longint b);
    bit     neg;
    longint ua, ub, q;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    q   = (ua * ub) >>> crb_pkg::FRAC_BITS;
    if (neg) begin
      if (q > -W_MIN) q = -W_MIN;
      q = -q;
    end else if (q > W_MAX) begin
      q = W_MAX;
    end
    return q;
  endfunction

  function automatic longint cubic_at(input longint x);
    longint t;
    t = cf_cube;
    t = clamp_w(fix_mul(t, x) + cf_square);
    t = clamp_w(fix_mul(t, x) + cf_linear);
    t = clamp_w(fix_mul(t, x) + cf_const);
    return t;
  endfunction

  function automatic bit opposite(input longint a, input longint b);
    return ((a > 0) && (b < 0)) || ((a < 0) && (b > 0));
  endfunction

  function automatic search_res_t solve_bracket(
      input logic signed [crb_pkg::WORD_W-1:0] lo_in,
      input logic signed [crb_pkg::WORD_W-1:0] hi_in);
    longint      lo, hi, mid, fm, rt;
    int unsigned n;
    bit          hit, narrow, done;
    search_res_t r;
    lo = lo_in;
    hi = hi_in;
    mid = 0;
    n = 0;
    hit = 1'b0;
    narrow = 1'b0;
    done = 1'b0;
    if (hi - lo < tol_q) begin
      narrow = 1'b1;
      rt = clamp_w(hi - lo);
    end else begin
      while (!done && (hi - lo >= tol_q)) begin
        mid = (lo + hi) >>> 1;
        fm  = cubic_at(mid);
        if (opposite(fm, cubic_at(lo))) hi = mid;
        else if (opposite(fm, cubic_at(hi))) lo = mid;
        n = (n + 1) & 16'hFFFF;
        // limit of zero acts as one
        if (n >= lim_q) begin
          hit  = 1'b1;
          done = 1'b1;
        end
      end
      rt = mid;
    end
    r.root         = rt[crb_pkg::WORD_W-1:0];
    r.limit_hit    = hit;
    r.narrow_start = narrow;
    r.iterations   = n[crb_pkg::ITER_W-1:0];
    return r;
  endfunction

  function automatic void apply_reg(input logic [crb_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [31:0] data);
    logic signed [31:0] sd;
    sd = data;
    case (idx)
      crb_pkg::REG_CUBE:   cf_cube = sd;
      crb_pkg::REG_SQUARE: cf_square = sd;
      crb_pkg::REG_LINEAR: cf_linear = sd;
      crb_pkg::REG_CONST:  cf_const = sd;
      crb_pkg::REG_TOL:    tol_q = longint'(data[crb_pkg::TOL_W-1:0]);
      crb_pkg::REG_LIMIT:  lim_q = data[crb_pkg::ITER_W-1:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void add_cfg(input logic [crb_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [31:0] data);
    dir_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = data;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_pred(input logic signed [crb_pkg::WORD_W-1:0] lo,
                                   input logic signed [crb_pkg::WORD_W-1:0] hi);
    dir_row_t row;
    row = '{default: '0};
    row.lo = lo;
    row.hi = hi;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_typed(input logic signed [crb_pkg::WORD_W-1:0] lo,
                                    input logic signed [crb_pkg::WORD_W-1:0] hi,
                                    input logic signed [crb_pkg::WORD_W-1:0] root,
                                    input logic hit, input logic narrow,
                                    input logic [crb_pkg::ITER_W-1:0] iters);
    dir_row_t row;
    row = '{default: '0};
    row.lo    = lo;
    row.hi    = hi;
    row.typed = 1'b1;
    row.res   = '{root, hit, narrow, iters};
    dir_rows.push_back(row);
  endfunction

  task automatic write_reg(input logic [crb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, data);
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_bracket(input logic signed [crb_pkg::WORD_W-1:0] lo,
                              input logic signed [crb_pkg::WORD_W-1:0] hi,
                              input bit typed, input search_res_t typed_res);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    lower_i    <= lo;
    upper_i    <= hi;
    do @(posedge clk_i); while (in_stall_o);
    pending_searches.push_back(typed ? typed_res : solve_bracket(lo, hi));
    items_sent++;
  endtask

  // stop sending and wait until every search has reported
  task automatic drain_searches();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_searches.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] small_coef();
    longint v;
    v = longint'($urandom_range(0, 32 * 65536)) - 16 * ONE_Q;
    return v[31:0];
  endfunction

  task automatic program_phase(input int ph);
    logic [31:0]                tol_draw, lim_draw;
    logic [crb_pkg::TOL_W-1:0]  tol;
    logic [crb_pkg::ITER_W-1:0] lim;
    tol_draw = (ph == 3) ? $urandom_range(1, 1 << 20) :
               (ph == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 4096);
    lim_draw = (ph == 1) ? $urandom_range(1, 200) :
               (ph == 2) ? 32'd64 : (ph == 3) ? 32'hFFFF : 32'd1000;
    tol = tol_draw[crb_pkg::TOL_W-1:0];
    lim = lim_draw[crb_pkg::ITER_W-1:0];
    write_reg(crb_pkg::REG_CUBE,   (ph == 2) ? $urandom : small_coef());
    write_reg(crb_pkg::REG_SQUARE, (ph == 2) ? $urandom : small_coef());
    write_reg(crb_pkg::REG_LINEAR, (ph == 2) ? $urandom : small_coef());
    write_reg(crb_pkg::REG_CONST,  (ph == 2) ? $urandom : small_coef());
    write_reg(crb_pkg::REG_TOL,    {1'($urandom_range(0, 1)), tol});
    write_reg(crb_pkg::REG_LIMIT,  {16'($urandom), lim});
  endtask

  task automatic random_phase(input int ph);
    longint                            a, b;
    logic signed [crb_pkg::WORD_W-1:0] lo, hi;
    int                                tries, sel, k;
    bit                                ok;
    search_res_t                       probe;
    for (k = 0; k < ITEMS_PER_PHASE; k++) begin
      if (k == ITEMS_PER_PHASE / 2) drain_searches();
      ok = 1'b0;
      // at the top limit, keep stuck brackets from running 65535 rounds
      for (tries = 0; tries < ((ph == 3) ? 20 : 1) && !ok; tries++) begin
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
          // bracket with a sign change, as far as a few tries find one
          for (int j = 0; j < 8; j++) begin
            a = longint'($urandom_range(0, 80 * 65536)) - 40 * ONE_Q;
            b = a + longint'($urandom_range(1, 48 * 65536));
            if (opposite(cubic_at(a), cubic_at(b))) break;
          end
        end else if (sel < 75) begin
          a = longint'(signed'($urandom));
          b = longint'(signed'($urandom));
        end else if (sel < 90) begin
          // around the tolerance boundary, inverted now and then
          a = longint'($urandom_range(0, 2000 * 65536)) - 1000 * ONE_Q;
          b = a + longint'($urandom_range(0, 2 * tol_q)) - tol_q;
        end else begin
          a = -longint'($urandom_range(0, 32'h7FFFFFFF));
          b = longint'($urandom_range(0, 32'h7FFFFFFF));
        end
        a  = clamp_w(a);
        b  = clamp_w(b);
        lo = a[crb_pkg::WORD_W-1:0];
        hi = b[crb_pkg::WORD_W-1:0];
        if (ph == 3) begin
          probe = solve_bracket(lo, hi);
          ok    = (probe.iterations <= 2000);
        end else begin
          ok = 1'b1;
        end
      end
      push_bracket(lo, hi, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------- checking

  always @(negedge clk_i) out_stall_i <= ($urandom_range(0, 99) < stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (narrow_start_o) narrow_seen++;
      if (limit_hit_o) hit_seen++;
      if (pending_searches.size() == 0) begin
        $error("result with no search pending: root %0d", root_o);
        fail_cnt++;
      end else begin
        want = pending_searches.pop_front();
        if (root_o !== want.root) begin
          $error("root: expected %0d, got %0d", want.root, root_o);
          fail_cnt++;
        end
        if (limit_hit_o !== want.limit_hit) begin
          $error("limit_hit: expected %0d, got %0d", want.limit_hit, limit_hit_o);
          fail_cnt++;
        end
        if (narrow_start_o !== want.narrow_start) begin
          $error("narrow_start: expected %0d, got %0d", want.narrow_start, narrow_start_o);
          fail_cnt++;
        end
        if (iterations_o !== want.iterations) begin
          $error("iterations: expected %0d, got %0d", want.iterations, iterations_o);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog: cycles in a row with no item moving on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("watchdog: no item moved in %0d cycles", idle_cycles);
      $display("cubic_root_bisection verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    lower_i = '0;
    upper_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    idle_cycles = 0;
    fail_cnt = 0;
    items_sent = 0;
    results_seen = 0;
    narrow_seen = 0;
    hit_seen = 0;
    cfg_writes = 0;
    cf_cube = signed'(crb_pkg::RST_CUBE);
    cf_square = signed'(crb_pkg::RST_SQUARE);
    cf_linear = signed'(crb_pkg::RST_LINEAR);
    cf_const = signed'(crb_pkg::RST_CONST);
    tol_q = longint'(crb_pkg::RST_TOL);
    lim_q = crb_pkg::RST_LIMIT;

    // reset cubic x^3 - 9x + 3, tolerance 66, limit 1000
    add_typed(0, 0, 0, 1'b0, 1'b1, 0);
    add_typed(100, 0, -100, 1'b0, 1'b1, 0);
    add_typed(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 1'b0, 1'b1, 0);
    add_typed(10, 75, 65, 1'b0, 1'b1, 0);
    add_pred(10, 76);
    add_pred(0, 65536);
    add_pred(-4 * 65536, 0);
    add_pred(32'sh80000000, 32'sh7FFFFFFF);
    // no sign change on [5, 6]: bracket never moves
    add_typed(5 * 65536, 6 * 65536, 360448, 1'b1, 1'b0, 16'd1000);
    // x^3 - x, zero tolerance, zero limit
    add_cfg(crb_pkg::REG_CUBE, 32'h0001_0000);
    add_cfg(crb_pkg::REG_SQUARE, 32'h0);
    add_cfg(crb_pkg::REG_LINEAR, 32'hFFFF_0000);
    add_cfg(crb_pkg::REG_CONST, 32'h0);
    add_cfg(crb_pkg::REG_TOL, 32'h8000_0000);
    add_cfg(crb_pkg::REG_LIMIT, 32'h5A5A_0000);
    add_typed(-65536, 65536, 0, 1'b1, 1'b0, 1);   // midpoint is an exact root
    add_typed(0, 0, 0, 1'b1, 1'b0, 1);
    add_typed(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1, 1'b0, 1);
    add_cfg(crb_pkg::REG_LIMIT, 32'hABCD_0028);
    add_pred(-3 * 65536, 32768);
    // extreme register values
    add_cfg(crb_pkg::REG_CUBE, 32'h7FFF_FFFF);
    add_cfg(crb_pkg::REG_SQUARE, 32'h8000_0000);
    add_cfg(crb_pkg::REG_LINEAR, 32'h7FFF_FFFF);
    add_cfg(crb_pkg::REG_CONST, 32'h8000_0000);
    add_cfg(crb_pkg::REG_TOL, 32'hFFFF_FFFF);
    add_cfg(crb_pkg::REG_LIMIT, 32'h0000_FFFF);
    add_cfg(REG_SPARE, 32'hFFFF_FFFF);
    add_pred(32'sh80000000, 32'sh7FFFFFFF);
    add_pred(0, 32'sh7FFFFFFF);
    add_typed(32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 1'b0, 1'b1, 0);
    add_pred(-65536, 65536);

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain_searches();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        push_bracket(dir_rows[i].lo, dir_rows[i].hi, dir_rows[i].typed, dir_rows[i].res);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      drain_searches();
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 62; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 62; end
        default: begin send_idle_pct = 35; stall_pct = 35; end
      endcase
      program_phase(ph);
      random_phase(ph);
    end

    drain_searches();
    repeat (20) @(posedge clk_i);

    $display("covered %0d brackets and %0d register writes; %0d results checked",
             items_sent, cfg_writes, results_seen);
    $display("%0d searches stopped by the limit, %0d narrow starts, %0d mismatches",
             hit_seen, narrow_seen, fail_cnt);
    if (fail_cnt == 0) begin
      $display("cubic_root_bisection verification clean");
    end else begin
      $display("cubic_root_bisection verification failed");
    end
    $finish;
  end

endmodule
